// ===== src/wtm_pkg.sv =====
package wtm_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int MEAN_W     = 14;
  localparam int FRAC_W     = 4;
  localparam int WINDOW_DEF = 10;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_DRAIN,
    ST_MUL,
    ST_DIV
  } fsm_e;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctl_t;

endpackage

// ===== src/wtm_cell.sv =====
module wtm_cell (
  input  logic                            clk_i,
  input  wtm_pkg::cell_ctl_t              ctl_i,
  input  logic [wtm_pkg::SAMPLE_W-1:0]    sample_i,
  input  logic                            occupied_i,
  input  logic [wtm_pkg::SAMPLE_W-1:0]    left_val_i,
  input  logic                            left_ins_i,
  input  logic [wtm_pkg::SAMPLE_W-1:0]    right_val_i,
  output logic [wtm_pkg::SAMPLE_W-1:0]    val_o,
  output logic                            ins_o
);

  logic [wtm_pkg::SAMPLE_W-1:0] val_q, val_d;

  // empty cells act as +inf so new items land at the end of the sorted run
  assign ins_o = !occupied_i || (sample_i < val_q);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.drain) begin
      val_d = right_val_i;
    end else if (ctl_i.insert && ins_o) begin
      val_d = left_ins_i ? left_val_i : sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== src/wtm_div.sv =====
module wtm_div #(
  parameter int KEEP  = 6,
  parameter int SUM_W = 14
) (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic [SUM_W-1:0]              sum_i,
  output logic [wtm_pkg::MEAN_W-1:0]    quot_o
);

  localparam int X_W = SUM_W + wtm_pkg::FRAC_W;
  localparam longint unsigned RECIP = (64'd1 << X_W) / KEEP;
  localparam logic [X_W-1:0]   RECIP_C = X_W'(RECIP);
  localparam logic [X_W-1:0]   KEEP_C  = X_W'(KEEP);

  logic [X_W-1:0]   x_q;
  logic [2*X_W-1:0] prod_q;
  logic [X_W-1:0]   x_d;
  logic [X_W-1:0]   q0, qk, rem, quot;

  assign x_d = {sum_i, {wtm_pkg::FRAC_W{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q    <= x_d;
      prod_q <= (2*X_W)'(x_d) * (2*X_W)'(RECIP_C);
    end
  end

  // reciprocal estimate is low by at most one; fix with one compare
  assign q0   = prod_q[2*X_W-1 -: X_W];
  assign qk   = q0 * KEEP_C;
  assign rem  = x_q - qk;
  assign quot = (rem >= KEEP_C) ? q0 + 1'b1 : q0;

  assign quot_o = wtm_pkg::MEAN_W'(quot);

endmodule

// ===== src/windowed_trimmed_mean.sv =====
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_stall_o   | sample_i  [9:0]
// out     | output    | out_valid_o / out_stall_i | mean_q4_o [13:0]
//
// Samples enter at one per cycle while in the fill phase; each is insert-sorted into the cell chain.
// The WINDOW-th sample starts a drain of all WINDOW cells (one cell per cycle
// into the accumulator), then a reciprocal-multiply step and a correction
// step; input stays stalled through all of these, and longer if out stalls.
// rst_ni clears the fill count, FSM and output valid; cell contents are not reset.
// in_stall_o is high outside the fill phase; a held result never blocks filling.
module windowed_trimmed_mean #(
  parameter int WINDOW = wtm_pkg::WINDOW_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [wtm_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wtm_pkg::MEAN_W-1:0]    mean_q4_o
);

  localparam int TRIM  = WINDOW / 5;
  localparam int KEEP  = WINDOW - 2 * TRIM;
  localparam int CW    = $clog2(WINDOW);
  localparam int SUM_W = wtm_pkg::SAMPLE_W + $clog2(WINDOW);

  wtm_pkg::fsm_e      state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic               out_valid_q, out_valid_d;
  logic [wtm_pkg::MEAN_W-1:0] mean_q, mean_d;

  wtm_pkg::cell_ctl_t ctl;
  logic               accept, div_load;
  logic               keep_idx;
  logic [wtm_pkg::MEAN_W-1:0] quot;

  logic [wtm_pkg::SAMPLE_W-1:0] val [WINDOW];
  logic [WINDOW-1:0]            ins;

  assign accept     = in_valid_i && (state_q == wtm_pkg::ST_FILL);
  assign in_stall_o = (state_q != wtm_pkg::ST_FILL);
  assign ctl.insert = accept;
  assign ctl.drain  = (state_q == wtm_pkg::ST_DRAIN);

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic [wtm_pkg::SAMPLE_W-1:0] left_val, right_val;
    logic                         left_ins;

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_ins = 1'b0;
    end else begin : g_mid
      assign left_val = val[i-1];
      assign left_ins = ins[i-1];
    end
    if (i == WINDOW - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_notlast
      assign right_val = val[i+1];
    end

    wtm_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .sample_i   (sample_i),
      .occupied_i (IDX < count_q),
      .left_val_i (left_val),
      .left_ins_i (left_ins),
      .right_val_i(right_val),
      .val_o      (val[i]),
      .ins_o      (ins[i])
    );
  end

  wtm_div #(
    .KEEP (KEEP),
    .SUM_W(SUM_W)
  ) u_div (
    .clk_i (clk_i),
    .load_i(div_load),
    .sum_i (sum_q),
    .quot_o(quot)
  );

  // drain index counts sorted rank; only the middle ranks are summed
  assign keep_idx = ({1'b0, count_q} >= (CW+1)'(TRIM)) &&
                    ({1'b0, count_q} <  (CW+1)'(WINDOW - TRIM));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sum_d       = sum_q;
    div_load    = 1'b0;
    mean_d      = mean_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      wtm_pkg::ST_FILL: begin
        if (accept) begin
          if (count_q == CW'(WINDOW - 1)) begin
            count_d = '0;
            sum_d   = '0;
            state_d = wtm_pkg::ST_DRAIN;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
      end
      wtm_pkg::ST_DRAIN: begin
        if (keep_idx) begin
          sum_d = sum_q + SUM_W'(val[0]);
        end
        if (count_q == CW'(WINDOW - 1)) begin
          count_d = '0;
          state_d = wtm_pkg::ST_MUL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      wtm_pkg::ST_MUL: begin
        div_load = 1'b1;
        state_d  = wtm_pkg::ST_DIV;
      end
      wtm_pkg::ST_DIV: begin
        if (!out_valid_q || !out_stall_i) begin
          mean_d      = quot;
          out_valid_d = 1'b1;
          state_d     = wtm_pkg::ST_FILL;
        end
      end
      default: state_d = wtm_pkg::ST_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wtm_pkg::ST_FILL;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    mean_q <= mean_d;
  end

  assign out_valid_o = out_valid_q;
  assign mean_q4_o   = mean_q;

`ifndef SYNTH
  for (genvar k = 0; k < WINDOW - 1; k++) begin : g_chk_sorted
    localparam logic [CW-1:0] NXT = CW'(k + 1);
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == wtm_pkg::ST_FILL && NXT < count_q) |-> (val[k] <= val[k+1]))
      else $error("cell chain out of order");
  end

  a_result_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == wtm_pkg::ST_DIV))
    else $error("result appeared outside the divide step");

  a_drain_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wtm_pkg::ST_DRAIN && count_q == CW'(WINDOW - 1))
      |=> (state_q == wtm_pkg::ST_MUL))
    else $error("drain did not end after a full window");

  a_mul_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wtm_pkg::ST_MUL) |=> (state_q == wtm_pkg::ST_DIV && count_q == '0))
    else $error("multiply step not followed by divide step");
`endif

endmodule

// ===== tb/windowed_trimmed_mean_test.sv =====
`timescale 1ns / 1ps

module windowed_trimmed_mean_test;

  localparam int WINDOW = wtm_pkg::WINDOW_DEF;
  localparam int TRIM = WINDOW / 5;
  localparam int KEEP = WINDOW - 2 * TRIM;
  localparam int RANDOM_ITEMS = 1330;
  localparam int PHASE_LEN = 450;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int TAIL_CYCLES = 3 * WINDOW;
  localparam int STUCK_LIMIT = 4000;
  localparam logic [wtm_pkg::SAMPLE_W-1:0] SAMPLE_MAX = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [wtm_pkg::SAMPLE_W-1:0] sample_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [wtm_pkg::MEAN_W-1:0] mean_q4_o;

  logic [wtm_pkg::SAMPLE_W-1:0] pending_samples[$];
  logic [wtm_pkg::MEAN_W-1:0] expected_means[$];
  logic [wtm_pkg::MEAN_W-1:0] due_mean;

  // predictor copy of the window
  logic [wtm_pkg::SAMPLE_W-1:0] window_samples[WINDOW];
  int unsigned window_fill = 0;

  int unsigned samples_taken = 0;
  int unsigned means_seen = 0;
  int unsigned errors = 0;
  int unsigned stuck_cycles = 0;
  int unsigned hold_left = 0;
  bit held_off = 1'b0;

  windowed_trimmed_mean #(.WINDOW(WINDOW)) uut (.*);

  initial forever #1 clk_i = ~clk_i;

  function automatic logic [wtm_pkg::MEAN_W-1:0] window_trimmed_mean();
    logic [wtm_pkg::SAMPLE_W-1:0] ordered[WINDOW];
    logic [wtm_pkg::SAMPLE_W-1:0] swap;
    int unsigned sum;
    sum = 0;
    for (int i = 0; i < WINDOW; i++) ordered[i] = window_samples[i];
    for (int i = 0; i < WINDOW - 1; i++)
      for (int j = 0; j < WINDOW - 1 - i; j++)
        if (ordered[j] > ordered[j + 1]) begin
          swap = ordered[j];
          ordered[j] = ordered[j + 1];
          ordered[j + 1] = swap;
        end
    for (int i = TRIM; i < WINDOW - TRIM; i++) sum += ordered[i];
    return wtm_pkg::MEAN_W'((sum << wtm_pkg::FRAC_W) / KEEP);
  endfunction

  task automatic take_sample(input logic [wtm_pkg::SAMPLE_W-1:0] s);
    window_samples[window_fill] = s;
    window_fill++;
    if (window_fill == WINDOW) begin
      expected_means.push_back(window_trimmed_mean());
      window_fill = 0;
    end
  endtask

  function automatic int unsigned sender_gap_pct();
    if (samples_taken < PHASE_LEN) return 11;
    if (samples_taken < 2 * PHASE_LEN) return 53;
    return 0;
  endfunction

  function automatic int unsigned receiver_gap_pct();
    if (samples_taken < PHASE_LEN) return 53;
    if (samples_taken < 2 * PHASE_LEN) return 11;
    return 0;
  endfunction

  // sample driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        take_sample(sample_i);
        samples_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= sender_gap_pct()) begin
          in_valid_i <= 1'b1;
          sample_i <= pending_samples.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // mean monitor and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        means_seen++;
        if (expected_means.size() == 0) begin
          errors++;
          $display("%0t: mean_q4 expected none, got %0d", $time, mean_q4_o);
        end else begin
          due_mean = expected_means.pop_front();
          if (mean_q4_o !== due_mean) begin
            errors++;
            $display("%0t: mean_q4 expected %0d, got %0d", $time, due_mean, mean_q4_o);
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!held_off && means_seen == 3) begin
        held_off = 1'b1;
        hold_left = HOLD_OFF_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < receiver_gap_pct());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned style;
    int unsigned base;
    logic [wtm_pkg::SAMPLE_W-1:0] s;

    // all equal at full scale, then alternating extremes, then a partial window
    repeat (WINDOW) pending_samples.push_back(SAMPLE_MAX);
    for (int k = 0; k < WINDOW; k++) pending_samples.push_back(k[0] ? SAMPLE_MAX : '0);
    pending_samples.push_back(wtm_pkg::SAMPLE_W'(0));
    pending_samples.push_back(wtm_pkg::SAMPLE_W'(1));
    pending_samples.push_back(wtm_pkg::SAMPLE_W'(512));
    pending_samples.push_back(wtm_pkg::SAMPLE_W'(1022));
    pending_samples.push_back(wtm_pkg::SAMPLE_W'(341));

    for (int n = 0; n < RANDOM_ITEMS; n += WINDOW) begin
      style = $urandom_range(9);
      base = $urandom_range(1020);
      for (int k = 0; k < WINDOW; k++) begin
        if (style < 6) s = wtm_pkg::SAMPLE_W'($urandom_range(1023));
        else if (style < 8) s = $urandom_range(1) ? SAMPLE_MAX : '0;
        else s = wtm_pkg::SAMPLE_W'(base + $urandom_range(3));  // tight cluster, many ties
        pending_samples.push_back(s);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_samples.size() != 0 || in_valid_i || expected_means.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
